### rtl/crtr_pkg.sv
package crtr_pkg;

	// moduli and precomputed inverses
	localparam logic [29:0] MOD_A        = 30'd1073643521;
	localparam logic [29:0] MOD_B        = 30'd1073692673;
	localparam logic [30:0] MOD_C        = 31'd1073750017;
	localparam logic [59:0] MOD_AB       = 60'd1152763181911621633;
	localparam logic [29:0] INV_A_MOD_B  = 30'd357919402;
	localparam logic [29:0] INV_AB_MOD_C = 30'd589973977;

	// halves of the product of the first two moduli, for the split multiply
	localparam logic [29:0] AB_LO = MOD_AB[29:0];
	localparam logic [29:0] AB_HI = MOD_AB[59:30];

	// number of register stages from input to result
	localparam int unsigned STAGES = 19;

	typedef struct packed {
		logic [29:0] residue_a;
		logic [29:0] residue_b;
		logic [30:0] residue_c;
	} crtr_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               too_wide;
	} crtr_result_t;

endpackage

### rtl/crtr_pipe_ctrl.sv
module crtr_pipe_ctrl #(
	parameter int unsigned DEPTH = 19
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	output logic           down_valid,
	input  logic           down_ready,
	output logic [DEPTH:1] en
);

	logic [DEPTH:1] valid_q;

	// a stage loads when it is empty or the stage after it moves on
	assign en[DEPTH] = !valid_q[DEPTH] || down_ready;

	for (genvar i = 1; i < DEPTH; i++) begin : g_en
		assign en[i] = !valid_q[i] || en[i+1];
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= up_valid;
			end
			for (int i = 2; i <= DEPTH; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign up_ready   = en[1];
	assign down_valid = valid_q[DEPTH];

endmodule

### rtl/crtr_barrett.sv
module crtr_barrett #(
	parameter int unsigned   N = 30,
	parameter logic [N-1:0]  M = 30'd1073692673
) (
	input  logic           clk,
	input  logic [2:0]     en,
	input  logic [2*N-1:0] x,
	output logic [N-1:0]   r
);

	// reciprocal of the modulus, worked out at elaboration
	localparam logic [2*N+1:0] TWO_2N = (2*N+2)'(1) << (2*N);
	localparam logic [N:0]     MU     = (N+1)'(TWO_2N / (2*N+2)'(M));
	localparam logic [N+1:0]   M1     = (N+2)'(M);
	localparam logic [N+1:0]   M2     = M1 << 1;

	logic [N:0]     q_s1;
	logic [N+1:0]   xl_s1;
	logic [N+1:0]   r_s2;
	logic [N-1:0]   r_s3;
	logic [2*N+1:0] qmu;
	logic [2*N:0]   qm;

	// quotient estimate from the top bits
	assign qmu = x[2*N-1:N-1] * MU;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1  <= qmu[2*N+1:N+1];
			xl_s1 <= x[N+1:0];
		end
	end

	// remainder estimate, below three times the modulus
	assign qm = q_s1 * M;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			r_s2 <= xl_s1 - qm[N+1:0];
		end
	end

	// final correction by up to two subtractions
	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (r_s2 >= M2) begin
				r_s3 <= N'(r_s2 - M2);
			end else if (r_s2 >= M1) begin
				r_s3 <= N'(r_s2 - M1);
			end else begin
				r_s3 <= N'(r_s2);
			end
		end
	end

	assign r = r_s3;

endmodule

### rtl/crt_three_moduli_reconstruct_unit.sv
// throughput: one transaction per cycle, a stall at the output holds the full stages
// the ready path runs combinationally back from the output through the valid bits
// reset clears the valid bits only; data registers are not reset
module crt_three_moduli_reconstruct_unit import crtr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  crtr_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output crtr_result_t result
);

	logic [STAGES:1] en;

	logic [29:0] ra_s1, rb_s1;
	logic [30:0] rc_s1;
	logic [29:0] ra_s2, d1_s2;
	logic [30:0] rc_s2;
	logic [59:0] t1_s3;
	logic [29:0] ra_s3, ra_s4, ra_s5, ra_s6, ra_s7;
	logic [30:0] rc_s3, rc_s4, rc_s5, rc_s6, rc_s7, rc_s8, rc_s9, rc_s10, rc_s11;
	logic [29:0] k1;
	logic [59:0] pa_s7;
	logic [59:0] y_s8, y_s9, y_s10, y_s11, y_s12, y_s13, y_s14, y_s15, y_s16, y_s17;
	logic [30:0] ym;
	logic [30:0] d2_s12;
	logic [61:0] t2_s13;
	logic [30:0] k2;
	logic [60:0] pl_s17, ph_s17, ph_s18;
	logic [61:0] sl_s18;
	logic [91:0] x_full;
	crtr_result_t res_s19;

	// stage control
	crtr_pipe_ctrl #(
		.DEPTH(STAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (item_valid),
		.up_ready   (item_ready),
		.down_valid (result_valid),
		.down_ready (result_ready),
		.en         (en)
	);

	// reduce residues that are at or above their modulus
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ra_s1 <= (item.residue_a >= MOD_A) ? item.residue_a - MOD_A : item.residue_a;
			rb_s1 <= (item.residue_b >= MOD_B) ? item.residue_b - MOD_B : item.residue_b;
			rc_s1 <= (item.residue_c >= MOD_C) ? item.residue_c - MOD_C : item.residue_c;
		end
	end

	// (b - a) mod mb
	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s2 <= (rb_s1 >= ra_s1) ? rb_s1 - ra_s1
			                          : 30'(31'(rb_s1) + 31'(MOD_B) - 31'(ra_s1));
			ra_s2 <= ra_s1;
			rc_s2 <= rc_s1;
		end
	end

	// times the inverse of ma
	always_ff @(posedge clk) begin
		if (en[3]) begin
			t1_s3 <= d1_s2 * INV_A_MOD_B;
			ra_s3 <= ra_s2;
			rc_s3 <= rc_s2;
		end
	end

	// first mixed-radix digit
	crtr_barrett #(
		.N(30),
		.M(MOD_B)
	) u_red_k1 (
		.clk (clk),
		.en  (en[6:4]),
		.x   (t1_s3),
		.r   (k1)
	);

	// carry residues alongside the reduction
	always_ff @(posedge clk) begin
		if (en[4]) begin
			ra_s4 <= ra_s3;
			rc_s4 <= rc_s3;
		end
		if (en[5]) begin
			ra_s5 <= ra_s4;
			rc_s5 <= rc_s4;
		end
		if (en[6]) begin
			ra_s6 <= ra_s5;
			rc_s6 <= rc_s5;
		end
	end

	// y = a + ma * k1
	always_ff @(posedge clk) begin
		if (en[7]) begin
			pa_s7 <= MOD_A * k1;
			ra_s7 <= ra_s6;
			rc_s7 <= rc_s6;
		end
		if (en[8]) begin
			y_s8  <= 60'(ra_s7) + pa_s7;
			rc_s8 <= rc_s7;
		end
	end

	// y mod mc
	crtr_barrett #(
		.N(31),
		.M(MOD_C)
	) u_red_y (
		.clk (clk),
		.en  (en[11:9]),
		.x   ({2'b00, y_s8}),
		.r   (ym)
	);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			y_s9  <= y_s8;
			rc_s9 <= rc_s8;
		end
		if (en[10]) begin
			y_s10  <= y_s9;
			rc_s10 <= rc_s9;
		end
		if (en[11]) begin
			y_s11  <= y_s10;
			rc_s11 <= rc_s10;
		end
	end

	// (c - y) mod mc, then times the inverse of ma*mb
	always_ff @(posedge clk) begin
		if (en[12]) begin
			d2_s12 <= (rc_s11 >= ym) ? rc_s11 - ym
			                         : 31'(32'(rc_s11) + 32'(MOD_C) - 32'(ym));
			y_s12  <= y_s11;
		end
		if (en[13]) begin
			t2_s13 <= d2_s12 * INV_AB_MOD_C;
			y_s13  <= y_s12;
		end
	end

	// second mixed-radix digit
	crtr_barrett #(
		.N(31),
		.M(MOD_C)
	) u_red_k2 (
		.clk (clk),
		.en  (en[16:14]),
		.x   (t2_s13),
		.r   (k2)
	);

	always_ff @(posedge clk) begin
		if (en[14]) begin
			y_s14 <= y_s13;
		end
		if (en[15]) begin
			y_s15 <= y_s14;
		end
		if (en[16]) begin
			y_s16 <= y_s15;
		end
	end

	// ma*mb * k2 as two partial products
	always_ff @(posedge clk) begin
		if (en[17]) begin
			pl_s17 <= k2 * AB_LO;
			ph_s17 <= k2 * AB_HI;
			y_s17  <= y_s16;
		end
		if (en[18]) begin
			sl_s18 <= 62'(y_s17) + 62'(pl_s17);
			ph_s18 <= ph_s17;
		end
	end

	// full reconstruction and range flag
	assign x_full = 92'(sl_s18) + 92'({ph_s18, 30'b0});

	always_ff @(posedge clk) begin
		if (en[19]) begin
			res_s19.value    <= x_full[63:0];
			res_s19.too_wide <= |x_full[91:63];
		end
	end

	assign result = res_s19;

endmodule
